// File: sv/spq_pkg.sv
// Package for the stable priority queue: field widths, status and operation codes,
// and the entry and control structs that the cells and the top level share.
// No dependencies.
package spq_pkg;

    localparam int VALUE_W     = 32;
    localparam int PRIO_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;
    localparam int CAPACITY_DEF = 16;

    // Input channel layout: value in the low bits, priority above it.
    localparam int S_TDATA_W = 48;
    // Result channel layout: value, status, occupancy, padded to whole bytes.
    localparam int M_TDATA_W = 40;

    // Operation carried in tuser of the input channel.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Value returned by a remove on an empty queue.
    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    // Broadcast from the top level to every cell in the row.
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t entry;
    } ctrl_t;

endpackage

// File: sv/spq_cell.sv
// One slot of the sorted row: holds an entry and shifts it toward or away from
// the head. Depends on spq_pkg for the entry and control structs.
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::ctrl_t     ctrl,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               keep,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // The entry stays in place on an insert when it does not rank after the new one,
    // which puts equal priorities behind the entries already stored.
    assign keep = occupied && ($signed(entry_reg.prio) <= $signed(ctrl.entry.prio));

    // Take the new entry at the insertion point, shift right behind it, or
    // shift left toward the head on a remove.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert) begin
            if (!keep) begin
                entry_next = left_keep ? ctrl.entry : left_entry;
            end
        end else if (ctrl.remove) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: sv/stable_priority_queue.sv
// Stable priority queue: a row of compare-and-shift cells and the handshake logic.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   The input channel (s_) carries one item per operation: tuser selects insert or
//   remove, tdata carries the value and priority of an insert. Entries leave in
//   ascending priority number; entries of equal priority leave in arrival order.
//   The result channel (m_) returns one item for every input item: the removed head
//   value or the offered value of an insert, a status code and the occupancy.
//   A remove on an empty queue returns -1 with the empty status; an insert into a
//   full queue is dropped and returns the full status.
// Timing and throughput:
//   The result appears in the cycle after the item is accepted. Every cell compares
//   its own priority with the new one in parallel and shifts in the same cycle, so
//   one item is taken per cycle for any capacity while the output register is free.
// Reset:
//   aresetn clears the entry count and the output valid; the stored entries are
//   not cleared, since no slot at or above the count is ever returned.
// Stall:
//   The result sits in one output register. A new item is accepted when that
//   register is empty or being read in the same cycle; otherwise s_tready is low.
module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: item_value [31:0], item_priority [47:32].
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: operation (0 insert, 1 remove).
    input  logic                          s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // tdata: result_value [31:0], status [33:32], occupancy [38:34], zero [39].
    output logic [spq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [spq_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [spq_pkg::M_TDATA_W-1:0] m_tdata_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    spq_pkg::ctrl_t       ctrl;
    spq_pkg::entry_t      in_entry;
    logic [CNT_W+spq_pkg::OCC_W-1:0] occ_wide;

    logic [CAPACITY-1:0]  keep;
    spq_pkg::entry_t      cell_entry [CAPACITY];

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign in_entry.value = s_tdata[spq_pkg::VALUE_W-1:0];
    assign in_entry.prio  = s_tdata[spq_pkg::VALUE_W+spq_pkg::PRIO_W-1:spq_pkg::VALUE_W];

    // Control broadcast to the row; dropped inserts and empty removes leave it alone.
    always_comb begin
        ctrl.entry  = in_entry;
        ctrl.insert = accept && (s_tuser == spq_pkg::OP_INSERT) && !full;
        ctrl.remove = accept && (s_tuser == spq_pkg::OP_REMOVE) && !empty;
    end

    // Row of cells; slot 0 is the head.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic            occupied;
        logic            left_keep;
        spq_pkg::entry_t left_entry;
        spq_pkg::entry_t right_entry;

        assign occupied = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = in_entry;
        end else begin : g_body
            assign left_keep  = keep[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_entry = cell_entry[i];
        end else begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (occupied),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .keep        (keep[i]),
            .entry       (cell_entry[i])
        );
    end

    // Entry count follows the operations that change the row.
    always_comb begin
        count_next = count_reg;
        if (ctrl.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign occ_wide = {{spq_pkg::OCC_W{1'b0}}, count_next};

    // Result item, formed at the accept edge: value and status from the state before the update, occupancy after it.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[spq_pkg::VALUE_W+spq_pkg::STATUS_W+spq_pkg::OCC_W-1:
                         spq_pkg::VALUE_W+spq_pkg::STATUS_W] = occ_wide[spq_pkg::OCC_W-1:0];
            if (s_tuser == spq_pkg::OP_INSERT) begin
                m_tdata_next[spq_pkg::VALUE_W-1:0] = in_entry.value;
                m_tdata_next[spq_pkg::VALUE_W+spq_pkg::STATUS_W-1:spq_pkg::VALUE_W] =
                    full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
            end else if (empty) begin
                m_tdata_next[spq_pkg::VALUE_W-1:0] = spq_pkg::EMPTY_VALUE;
                m_tdata_next[spq_pkg::VALUE_W+spq_pkg::STATUS_W-1:spq_pkg::VALUE_W] =
                    spq_pkg::ST_EMPTY;
            end else begin
                m_tdata_next[spq_pkg::VALUE_W-1:0] = cell_entry[0].value;
                m_tdata_next[spq_pkg::VALUE_W+spq_pkg::STATUS_W-1:spq_pkg::VALUE_W] =
                    spq_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // The count never runs past the number of cells.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // The two head entries are in order whenever both are held.
    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |->
            ($signed(cell_entry[0].prio) <= $signed(cell_entry[1].prio)))
        else $error("head entries out of priority order");

    // A dropped insert leaves the count where it was.
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == spq_pkg::OP_INSERT) && full) |=> $stable(count_reg))
        else $error("insert into full queue changed the count");

    // Every accepted item leaves a result behind.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid_reg)
        else $error("accepted item produced no result");
`endif

endmodule

// File: sim/stable_priority_queue_tb.sv
// Self-checking testbench for stable_priority_queue: random and directed inserts and
// removes, checked against a sorted-array model of the queue kept in this file.
// Depends on spq_pkg and the stable_priority_queue RTL.
`timescale 1ns / 100ps

module stable_priority_queue_tb;

    localparam int CAPACITY   = spq_pkg::CAPACITY_DEF;
    localparam int RUN_ITEMS  = 1350;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_LEN   = 400;
    localparam int PRINT_MAX  = 50;

    // One operation waiting to be offered on the input channel.
    typedef struct {
        logic                              op;
        logic [spq_pkg::VALUE_W-1:0]       value;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        int                                gap;
    } queue_op_t;

    // What the queue should answer for one accepted operation.
    typedef struct {
        logic [spq_pkg::VALUE_W-1:0]  value;
        logic [spq_pkg::STATUS_W-1:0] status;
        logic [spq_pkg::OCC_W-1:0]    occupancy;
    } reply_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [spq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [spq_pkg::M_TDATA_W-1:0] m_tdata;

    // Operations still to be offered, and replies the queue still owes.
    queue_op_t offered_ops[$];
    reply_t    predicted_replies[$];
    queue_op_t cur_op;
    int        gap_left;
    int        ops_accepted = 0;

    // Sorted copy of the queue contents, head at slot 0.
    logic [spq_pkg::VALUE_W-1:0]       model_value[CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] model_prio[CAPACITY];
    int                                model_count = 0;

    // Run statistics and failure count.
    int n_insert = 0;
    int n_remove = 0;
    int n_full = 0;
    int n_empty = 0;
    int peak_occupancy = 0;
    int mismatch_count = 0;

    // Receiver side state.
    logic hold_off = 1'b0;
    int   pause_left;
    int   rx_calm_left;

    stable_priority_queue #(
        .CAPACITY(CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Applies one accepted operation to the model and returns the reply it causes.
    function automatic reply_t sorted_model_step(
        input logic op, input logic [spq_pkg::VALUE_W-1:0] value,
        input logic signed [spq_pkg::PRIO_W-1:0] prio);
        reply_t r;
        int     pos;
        r.value  = value;
        r.status = spq_pkg::ST_DONE;
        if (op == spq_pkg::OP_INSERT) begin
            n_insert++;
            if (model_count >= CAPACITY) begin
                r.status = spq_pkg::ST_FULL;
                n_full++;
            end else begin
                // New entry goes behind every entry of lower or equal priority number.
                pos = 0;
                while (pos < model_count && model_prio[pos] <= prio)
                    pos++;
                for (int i = model_count; i > pos; i--) begin
                    model_value[i] = model_value[i-1];
                    model_prio[i]  = model_prio[i-1];
                end
                model_value[pos] = value;
                model_prio[pos]  = prio;
                model_count++;
                if (model_count > peak_occupancy)
                    peak_occupancy = model_count;
            end
        end else begin
            n_remove++;
            if (model_count == 0) begin
                r.value  = spq_pkg::EMPTY_VALUE;
                r.status = spq_pkg::ST_EMPTY;
                n_empty++;
            end else begin
                r.value = model_value[0];
                for (int i = 1; i < model_count; i++) begin
                    model_value[i-1] = model_value[i];
                    model_prio[i-1]  = model_prio[i];
                end
                model_count--;
            end
        end
        r.occupancy = model_count[spq_pkg::OCC_W-1:0];
        return r;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [spq_pkg::VALUE_W-1:0] got,
                                   input logic [spq_pkg::VALUE_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_MAX)
            $display("%t: %s differs: got %h, want %h", $realtime, what, got, want);
    endtask

    task automatic queue_op(input logic op, input logic [spq_pkg::VALUE_W-1:0] value,
                            input logic signed [spq_pkg::PRIO_W-1:0] prio, input int gap);
        queue_op_t q;
        q.op    = op;
        q.value = value;
        q.prio  = prio;
        q.gap   = gap;
        offered_ops.push_back(q);
    endtask

    // Reset is held low at the start of the run, then released.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Input driver: offers queued operations and feeds each accepted one to the model.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_replies.push_back(sorted_model_step(cur_op.op, cur_op.value,
                                                              cur_op.prio));
                ops_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (offered_ops.size() > 0) begin
                    cur_op = offered_ops.pop_front();
                    s_tdata  <= {cur_op.prio, cur_op.value};
                    s_tuser  <= cur_op.op;
                    s_tvalid <= 1'b1;
                    gap_left = cur_op.gap;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, with calm stretches where it always takes the item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            pause_left = 0;
            rx_calm_left = 0;
        end else if (hold_off) begin
            m_tready <= 1'b0;
        end else if (pause_left > 0) begin
            pause_left--;
            m_tready <= 1'b0;
        end else if (rx_calm_left > 0) begin
            rx_calm_left--;
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 99) < 3) begin
            rx_calm_left = $urandom_range(30, 120);
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            pause_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Long receiver hold-off so that the output register fills and the input stalls.
    initial begin
        @(posedge aclk iff aresetn);
        while (ops_accepted < HOLD_AFTER)
            @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Result monitor: compares every item against the oldest outstanding reply.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                if (m_tdata[31:0] !== predicted_replies[0].value)
                    report_mismatch("result_value", m_tdata[31:0],
                                    predicted_replies[0].value);
                if (m_tdata[33:32] !== predicted_replies[0].status)
                    report_mismatch("status", spq_pkg::VALUE_W'(m_tdata[33:32]),
                                    spq_pkg::VALUE_W'(predicted_replies[0].status));
                if (m_tdata[38:34] !== predicted_replies[0].occupancy)
                    report_mismatch("occupancy", spq_pkg::VALUE_W'(m_tdata[38:34]),
                                    spq_pkg::VALUE_W'(predicted_replies[0].occupancy));
                void'(predicted_replies.pop_front());
            end
        end
    end

    // Stimulus: directed corner cases, then random bursts; then drain and judge.
    initial begin
        int   built;
        int   burst;
        int   ins_pct;
        int   prio_mode;
        int   pick;
        logic calm;
        logic op;
        logic signed [spq_pkg::PRIO_W-1:0] prio;

        // Remove on an empty queue.
        queue_op(spq_pkg::OP_REMOVE, 32'h1234_5678, 16'sh0000, 0);
        // Extreme values and priorities, plus ties at priority zero.
        queue_op(spq_pkg::OP_INSERT, 32'h7FFF_FFFF, 16'sh7FFF, 0);
        queue_op(spq_pkg::OP_INSERT, 32'h8000_0000, -16'sh8000, 0);
        queue_op(spq_pkg::OP_INSERT, 32'h0000_0000, 16'sh0000, 1);
        queue_op(spq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'sh0000, 0);
        queue_op(spq_pkg::OP_INSERT, 32'h0000_0001, 16'sh0000, 0);
        queue_op(spq_pkg::OP_INSERT, 32'h5555_5555, -16'sh0001, 2);
        queue_op(spq_pkg::OP_INSERT, 32'hAAAA_AAAA, 16'sh0001, 0);
        // Fill to capacity with ties at both ends of the priority range.
        for (int i = 0; i < 9; i++) begin
            case (i % 3)
                0: prio = 16'sh7FFF;
                1: prio = -16'sh8000;
                default: prio = 16'sh0000;
            endcase
            queue_op(spq_pkg::OP_INSERT, 32'h100 + i, prio, 0);
        end
        // Insert into a full queue is dropped.
        queue_op(spq_pkg::OP_INSERT, 32'hDEAD_BEEF, 16'sh0002, 0);
        for (int i = 0; i < 5; i++)
            queue_op(spq_pkg::OP_REMOVE, $urandom, 16'($urandom), 0);
        queue_op(spq_pkg::OP_INSERT, 32'hCAFE_0001, -16'sh8000, 0);
        built = offered_ops.size();

        // Random bursts that swing the occupancy between empty and full.
        while (built < RUN_ITEMS) begin
            burst = $urandom_range(25, 60);
            case ($urandom_range(0, 2))
                0: ins_pct = 15;
                1: ins_pct = 50;
                default: ins_pct = 85;
            endcase
            prio_mode = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT
                                                        : spq_pkg::OP_REMOVE;
                case (prio_mode)
                    0: prio = spq_pkg::PRIO_W'($urandom_range(0, 6) - 3);
                    1: begin
                        pick = $urandom_range(0, 4);
                        case (pick)
                            0: prio = -16'sh8000;
                            1: prio = 16'sh7FFF;
                            2: prio = -16'sh0001;
                            3: prio = 16'sh0000;
                            default: prio = 16'sh0001;
                        endcase
                    end
                    default: prio = spq_pkg::PRIO_W'($urandom);
                endcase
                queue_op(op, $urandom, prio, calm ? 0 : pick_gap());
                built++;
            end
        end

        // Wait for the input side to empty, then for every owed reply.
        @(posedge aclk iff aresetn);
        while (offered_ops.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (predicted_replies.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);

        $display("Ran %0d inserts (%0d dropped on a full queue) and %0d removes",
                 n_insert, n_full, n_remove);
        $display("(%0d on an empty queue); peak occupancy %0d of %0d.",
                 n_empty, peak_occupancy, CAPACITY);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard limit on run time, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Timeout: %0d replies still outstanding", predicted_replies.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
sim/stable_priority_queue_tb.sv
